// ===== design/bfah_pkg.sv =====
package bfah_pkg;

    // filter geometry and key limits
    localparam int FILTER_BITS   = 50;
    localparam int MAX_KEY_BYTES = 32767;

    // fixed field widths of the item and result beats
    localparam int FUNC_W  = 2;
    localparam int BYTE_W  = 7;
    localparam int INDEX_W = 10;

    // internal widths derived from the limits
    localparam int IDX_W  = (FILTER_BITS > 1) ? $clog2(FILTER_BITS) : 1;
    localparam int LEN_W  = $clog2(MAX_KEY_BYTES + 1);
    localparam int BYTE3_W = BYTE_W + 2;
    localparam int SUM_W  = $clog2(MAX_KEY_BYTES * 381 + 1);
    localparam int V_W    = $clog2(MAX_KEY_BYTES * 381 + 3 * MAX_KEY_BYTES + 1);

    // reciprocal of the filter size, exact quotient for any V_W-bit value
    localparam int RECIP_SH = V_W + IDX_W;
    localparam int RECIP_W  = V_W + 1;
    localparam int PROD_W   = V_W + RECIP_W;
    localparam int QUOT_W   = PROD_W - RECIP_SH;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SH) + 64'(FILTER_BITS) - 64'd1) / 64'(FILTER_BITS));

    // key-end queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    // operation codes on the func field
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [BYTE_W-1:0] key_byte;
        logic              last_byte;
    } t_item;

    typedef struct packed {
        logic               present;
        logic [INDEX_W-1:0] first_index;
        logic [INDEX_W-1:0] second_index;
        logic [INDEX_W-1:0] third_index;
        logic               too_long;
    } t_result;

    typedef enum logic [1:0] {
        OP_INSERT,
        OP_QUERY,
        OP_CLEAR
    } t_op;

    // one finished key or clear request
    typedef struct packed {
        t_op              op;
        logic             too_long;
        logic [SUM_W-1:0] sum;
        logic [LEN_W-1:0] len;
    } t_job;

endpackage

// ===== design/bloom_filter_additive_hash_core.sv =====
// bloom filter over FILTER_BITS bits with three additive hashes. key bytes
// come in one beat per cycle (start high, busy low); the front end adds
// 3*byte and counts the length in that same cycle. a key end (last_byte)
// or a clear goes into a two-entry queue. the back end pops one entry at a
// time: a clear or an overlong key is done at the pop, a normal key steps
// through popping and forming the three sums, multiplying them by the
// reciprocal of the filter size, subtracting back to the three indices,
// three accesses through the single port of the filter bit memory and a
// finish. the result strobe is registered and comes in the cycle after
// the pop of a clear or overlong key, or after the finish. busy is high
// while the queue is full, which only happens when key ends and clears
// arrive faster than the back end pops them. each result is shown for
// exactly one cycle with o_strobe high; the receiver cannot stall it. the
// filter is empty after reset and after a clear, both take effect at once
// through per-bit valid flags
module bloom_filter_additive_hash_core
    import bfah_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_item   i_item,
    output logic    o_strobe,
    output t_result o_result
);

    logic accept;
    logic push, pop, q_full, q_empty;
    t_job push_job, pop_job;

    // a beat is taken whenever the queue has room for its possible key end
    assign busy   = q_full;
    assign accept = start && !busy;

    bfah_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_item),
        .o_push   (push),
        .o_job    (push_job)
    );

    // decouples byte streaming from hash and filter work
    bfah_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_job   (pop_job)
    );

    // index generation, filter update or lookup, result register
    bfah_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (q_empty),
        .i_job    (pop_job),
        .o_pop    (pop),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

// ===== design/bfah_front.sv =====
module bfah_front
    import bfah_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_accept,
    input  t_item i_item,
    output logic  o_push,
    output t_job  o_job
);

    logic [SUM_W-1:0]   r_sum, n_sum;
    logic [LEN_W-1:0]   r_len, n_len;
    logic               r_ovf, n_ovf;
    logic [BYTE3_W-1:0] byte3;
    logic [SUM_W-1:0]   acc_sum;
    logic [LEN_W-1:0]   acc_len;
    logic               acc_ovf;

    assign byte3 = BYTE3_W'({i_item.key_byte, 1'b0}) + BYTE3_W'(i_item.key_byte);

    // per-byte accumulate, capped at the maximum key length
    always_comb begin
        if (r_len < LEN_W'(MAX_KEY_BYTES)) begin
            acc_sum = r_sum + SUM_W'(byte3);
            acc_len = r_len + LEN_W'(1);
            acc_ovf = r_ovf;
        end else begin
            acc_sum = r_sum;
            acc_len = r_len;
            acc_ovf = 1'b1;
        end
    end

    always_comb begin
        n_sum    = r_sum;
        n_len    = r_len;
        n_ovf    = r_ovf;
        o_push   = 1'b0;
        o_job    = '0;
        o_job.op = OP_INSERT;
        if (i_accept) begin
            case (i_item.func)
                FUNC_CLEAR: begin
                    o_push   = 1'b1;
                    o_job.op = OP_CLEAR;
                    n_sum    = '0;
                    n_len    = '0;
                    n_ovf    = 1'b0;
                end
                FUNC_INSERT, FUNC_QUERY: begin
                    if (i_item.last_byte) begin
                        o_push         = 1'b1;
                        o_job.op       = (i_item.func == FUNC_INSERT) ? OP_INSERT : OP_QUERY;
                        o_job.too_long = acc_ovf;
                        o_job.sum      = acc_sum;
                        o_job.len      = acc_len;
                        n_sum          = '0;
                        n_len          = '0;
                        n_ovf          = 1'b0;
                    end else begin
                        n_sum = acc_sum;
                        n_len = acc_len;
                        n_ovf = acc_ovf;
                    end
                end
                default: begin
                    n_sum = r_sum;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_len <= '0;
            r_ovf <= 1'b0;
        end else begin
            r_sum <= n_sum;
            r_len <= n_len;
            r_ovf <= n_ovf;
        end
    end

endmodule

// ===== design/bfah_queue.sv =====
module bfah_queue
    import bfah_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_job o_job
);

    t_job              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push, do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + QPTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== design/bfah_back.sv =====
module bfah_back
    import bfah_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_empty,
    input  t_job    i_job,
    output logic    o_pop,
    output logic    o_strobe,
    output t_result o_result
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_REM  = 4'b0100,
        ST_MEM  = 4'b1000
    } t_state;

    t_state             r_state;
    t_op                r_op;
    logic [V_W-1:0]     r_v   [3];
    logic [QUOT_W-1:0]  r_q   [3];
    logic [INDEX_W-1:0] r_rem [3];
    logic [1:0]         r_step;
    logic               r_hit;
    logic               r_mem [FILTER_BITS];
    logic [FILTER_BITS-1:0] r_valid;
    logic               r_rd_bit, r_rd_valid;
    logic               r_strobe;
    t_result            r_result;

    logic [V_W-1:0]     len_x1, len_x2, len_x3, sum_v;
    logic [PROD_W-1:0]  prod     [3];
    logic [V_W-1:0]     rem_full [3];
    logic [1:0]         sel;
    logic [IDX_W-1:0]   addr;
    logic               mem_access, mem_we, rd_hit;

    assign o_pop  = (r_state == ST_IDLE) && !i_empty;
    assign sum_v  = V_W'(i_job.sum);
    assign len_x1 = V_W'(i_job.len);
    assign len_x2 = {len_x1[V_W-2:0], 1'b0};
    assign len_x3 = len_x2 + len_x1;

    // quotient by reciprocal multiply, then remainder by subtracting back
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            prod[k]     = PROD_W'(r_v[k]) * PROD_W'(RECIP);
            rem_full[k] = r_v[k] - V_W'(r_q[k]) * V_W'(FILTER_BITS);
        end
    end

    assign sel        = (r_step == 2'd3) ? 2'd2 : r_step;
    assign addr       = r_rem[sel][IDX_W-1:0];
    assign mem_access = (r_state == ST_MEM) && (r_step != 2'd3);
    assign mem_we     = mem_access && (r_op == OP_INSERT);
    assign rd_hit     = r_rd_bit && r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[addr] <= 1'b1;
        end
        r_rd_bit   <= r_mem[addr];
        r_rd_valid <= r_valid[addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_valid  <= '0;
            r_strobe <= 1'b0;
            r_op     <= OP_INSERT;
            r_step   <= '0;
            r_hit    <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (!i_empty) begin
                        r_op <= i_job.op;
                        if (i_job.op == OP_CLEAR) begin
                            r_valid  <= '0;
                            r_strobe <= 1'b1;
                            r_result <= '0;
                        end else if (i_job.too_long) begin
                            r_strobe <= 1'b1;
                            r_result <= '{present: 1'b0, first_index: '0, second_index: '0,
                                          third_index: '0, too_long: 1'b1};
                        end else begin
                            r_v[0]  <= sum_v + len_x1;
                            r_v[1]  <= sum_v + len_x2;
                            r_v[2]  <= sum_v + len_x3;
                            r_state <= ST_DIV;
                        end
                    end
                end
                ST_DIV: begin
                    for (int k = 0; k < 3; k++) begin
                        r_q[k] <= prod[k][PROD_W-1:RECIP_SH];
                    end
                    r_state <= ST_REM;
                end
                ST_REM: begin
                    for (int k = 0; k < 3; k++) begin
                        r_rem[k] <= rem_full[k][INDEX_W-1:0];
                    end
                    r_step  <= '0;
                    r_hit   <= 1'b1;
                    r_state <= ST_MEM;
                end
                ST_MEM: begin
                    if (mem_we) begin
                        r_valid[addr] <= 1'b1;
                    end
                    if (r_step != 2'd0) begin
                        r_hit <= r_hit && rd_hit;
                    end
                    r_step <= r_step + 2'd1;
                    if (r_step == 2'd3) begin
                        r_strobe              <= 1'b1;
                        r_result.present      <= (r_op == OP_QUERY) && r_hit && rd_hit;
                        r_result.first_index  <= r_rem[0];
                        r_result.second_index <= r_rem[1];
                        r_result.third_index  <= r_rem[2];
                        r_result.too_long     <= 1'b0;
                        r_state               <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule
